@@ hdl/fee_pkg.sv @@
// Shared constants, types and helper functions of the flash EEPROM emulation store.
package fee_pkg;

    localparam int SLOTS_PER_PAGE = 256;
    localparam int NUM_VARS       = 200;

    localparam int DW  = 64;                          // slot width
    localparam int SW  = $clog2(SLOTS_PER_PAGE);      // slot index in a page
    localparam int AW  = $clog2(2 * SLOTS_PER_PAGE);  // slot address in the memory
    localparam int WPW = $clog2(SLOTS_PER_PAGE + 1);  // append pointer, may hold the page size
    localparam int VW  = $clog2(NUM_VARS + 1);        // variable counter, may hold NUM_VARS

    typedef logic [1:0]  t_cmd;
    typedef logic [2:0]  t_st;
    typedef logic [1:0]  t_hdr;
    typedef logic [1:0]  t_pgsel;
    typedef logic [1:0]  t_smode;

    localparam t_cmd CMD_READ  = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_INIT  = 2'd2;

    localparam t_st ST_OK     = 3'd0;
    localparam t_st ST_NODATA = 3'd1;
    localparam t_st ST_NOPAGE = 3'd2;
    localparam t_st ST_WERR   = 3'd3;
    localparam t_st ST_NOINIT = 3'd4;

    localparam logic [DW-1:0] HDR_ERASED  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DW-1:0] HDR_VALID   = 64'h0000_0000_0000_0000;
    localparam logic [DW-1:0] HDR_RECEIVE = 64'h0000_0000_AAAA_AAAA;

    // cached header state of a page
    localparam t_hdr HC_ERASED = 2'd0;
    localparam t_hdr HC_RECV   = 2'd1;
    localparam t_hdr HC_VALID  = 2'd2;

    localparam t_pgsel PG_0    = 2'd0;
    localparam t_pgsel PG_1    = 2'd1;
    localparam t_pgsel PG_NONE = 2'd2;

    // scan match modes
    localparam t_smode SM_ERASED = 2'd0;  // first erased slot
    localparam t_smode SM_ADDR   = 2'd1;  // programmed slot with matching address
    localparam t_smode SM_ANY    = 2'd2;  // first slot visited

    typedef struct packed {
        logic          start;
        logic          page;
        logic          down;
        t_smode        mode;
        logic [15:0]   key;
    } t_scan_req;

    typedef struct packed {
        logic          done;
        logic          hit;
        logic [SW-1:0] slot;
        logic [15:0]   addr;
        logic [15:0]   value;
    } t_scan_rsp;

    function automatic logic [AW-1:0] slot_addr(input logic pg, input logic [SW-1:0] idx);
        slot_addr = AW'(idx) + (pg ? AW'(SLOTS_PER_PAGE) : AW'(0));
    endfunction

    function automatic t_pgsel find_read(input t_hdr h0, input t_hdr h1);
        if (h0 == HC_VALID)      find_read = PG_0;
        else if (h1 == HC_VALID) find_read = PG_1;
        else                     find_read = PG_NONE;
    endfunction

    function automatic t_pgsel find_write(input t_hdr h0, input t_hdr h1);
        if (h1 == HC_VALID)      find_write = (h0 == HC_RECV) ? PG_0 : PG_1;
        else if (h0 == HC_VALID) find_write = (h1 == HC_RECV) ? PG_1 : PG_0;
        else                     find_write = PG_NONE;
    endfunction

    function automatic t_pgsel find_erased(input t_hdr h0, input t_hdr h1);
        if (h0 == HC_ERASED)      find_erased = PG_0;
        else if (h1 == HC_ERASED) find_erased = PG_1;
        else                      find_erased = PG_NONE;
    endfunction

endpackage

@@ hdl/fee_if.sv @@
// Request and response channel interfaces of the flash EEPROM emulation store.
interface fee_in_if import fee_pkg::*; ();
    logic        valid;
    logic        ready;
    t_cmd        command;
    logic [15:0] var_address;
    logic [15:0] write_value;

    modport source (output valid, command, var_address, write_value, input ready);
    modport sink   (input valid, command, var_address, write_value, output ready);
endinterface

interface fee_out_if import fee_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] rd_value;
    t_st         status;

    modport source (output valid, rd_value, status, input ready);
    modport sink   (input valid, rd_value, status, output ready);
endinterface

@@ hdl/fee_ram.sv @@
// Generic simple dual-port RAM with registered read.
module fee_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/fee_scan.sv @@
// Shared slot scan unit: walks one page up or down, one slot a cycle, and compares.
module fee_scan import fee_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_scan_req     i_req,
    input  logic [DW-1:0] i_rdata,
    output logic [AW-1:0] o_rd_addr,
    output t_scan_rsp     o_rsp
);
    logic          r_busy;
    logic          r_iss;
    logic          r_chk;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_chk_idx;
    logic          r_page;
    logic          r_down;
    t_smode        r_mode;
    logic [15:0]   r_key;
    logic          r_done;
    logic          r_hit;
    logic [SW-1:0] r_slot;
    logic [15:0]   r_addr;
    logic [15:0]   r_val;

    logic          w_erased;
    logic          w_match;
    logic [SW-1:0] w_last;

    assign w_erased = (i_rdata == HDR_ERASED);
    assign w_last   = r_down ? SW'(1) : SW'(SLOTS_PER_PAGE - 1);

    always_comb begin
        case (r_mode)
            SM_ERASED: w_match = w_erased;
            SM_ADDR:   w_match = !w_erased && (i_rdata[47:32] == r_key);
            default:   w_match = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iss  <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iss  <= 1'b1;
                r_chk  <= 1'b0;
                r_idx  <= i_req.down ? SW'(SLOTS_PER_PAGE - 1) : SW'(1);
                r_page <= i_req.page;
                r_down <= i_req.down;
                r_mode <= i_req.mode;
                r_key  <= i_req.key;
            end else if (r_busy) begin
                if (r_chk && (w_match || r_chk_idx == w_last)) begin
                    r_busy <= 1'b0;
                    r_iss  <= 1'b0;
                    r_chk  <= 1'b0;
                    r_done <= 1'b1;
                    r_hit  <= w_match;
                    r_slot <= r_chk_idx;
                    r_addr <= i_rdata[47:32];
                    r_val  <= i_rdata[63:48];
                end else begin
                    // read data arrives in the cycle after its index is issued
                    r_chk     <= r_iss;
                    r_chk_idx <= r_idx;
                    if (r_iss) begin
                        if (r_idx == w_last) begin
                            r_iss <= 1'b0;
                        end else if (r_down) begin
                            r_idx <= r_idx - SW'(1);
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end
                end
            end
        end
    end

    assign o_rd_addr = slot_addr(r_page, r_idx);
    assign o_rsp     = {r_done, r_hit, r_slot, r_addr, r_val};
endmodule

@@ hdl/flash_eeprom_emulation.sv @@
// Top level of the two-page flash EEPROM emulation store: sequencer, header cache, RAM.
//
//  channel | dir | handshake     | payload
//  i_req   | in  | valid / ready | command, var_address, write_value
//  o_rsp   | out | valid / ready | rd_value, status
//
// One request at a time; i_req.ready is high only when the sequencer is idle and the
// response register is empty. The slot scan unit visits one slot per cycle through the
// RAM read port for a read or an append. A page transfer looks up each other variable
// with one backward scan of the active page; a page erase writes every slot of the
// page. After reset a clearing pass writes all 2 * SLOTS_PER_PAGE slots before the
// first request is taken. A stalled response holds.
module flash_eeprom_emulation import fee_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fee_in_if.sink    i_req,
    fee_out_if.source o_rsp
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERASE  = 4'd1;
    localparam logic [3:0] S_RSCAN  = 4'd2;
    localparam logic [3:0] S_WSCAN  = 4'd3;
    localparam logic [3:0] S_XSTART = 4'd4;
    localparam logic [3:0] S_XFIRST = 4'd5;
    localparam logic [3:0] S_XVAR   = 4'd6;
    localparam logic [3:0] S_XVSCAN = 4'd7;
    localparam logic [3:0] S_XEND   = 4'd8;
    localparam logic [3:0] S_RECRD  = 4'd9;
    localparam logic [3:0] S_FMT1   = 4'd10;
    localparam logic [3:0] S_FINOK  = 4'd11;

    // control state
    logic [3:0]     r_state, n_state;
    logic [3:0]     r_ret,   n_ret;
    logic [AW-1:0]  r_er_addr, n_er_addr;
    logic [AW-1:0]  r_er_end,  n_er_end;
    t_hdr           r_h0, n_h0;
    t_hdr           r_h1, n_h1;
    logic           r_ready, n_ready;
    logic           r_ovld, n_ovld;
    // request context and transfer payload
    t_cmd           r_cmd, n_cmd;
    logic [15:0]    r_key, n_key;
    logic [15:0]    r_data, n_data;
    logic           r_act, n_act;
    logic           r_nw,  n_nw;
    logic           r_recov, n_recov;
    logic [WPW-1:0] r_wptr, n_wptr;
    logic [VW-1:0]  r_var, n_var;
    logic [15:0]    r_oval, n_oval;
    t_st            r_ost, n_ost;

    // RAM and scan unit
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [DW-1:0]  w_wdata;
    logic [AW-1:0]  w_raddr;
    logic [DW-1:0]  w_rdata;
    t_scan_req      w_sq;
    t_scan_rsp      w_sr;

    logic           w_fin;
    t_st            w_fst;
    logic [15:0]    w_fval;
    t_cmd           w_fcmd;

    fee_ram #(.WIDTH(DW), .DEPTH(2 * SLOTS_PER_PAGE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fee_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_sq),
        .i_rdata   (w_rdata),
        .o_rd_addr (w_raddr),
        .o_rsp     (w_sr)
    );

    assign i_req.ready    = (r_state == S_IDLE) && !r_ovld;
    assign o_rsp.valid    = r_ovld;
    assign o_rsp.rd_value = r_oval;
    assign o_rsp.status   = r_ost;

    always_comb begin
        t_pgsel pr;
        t_pgsel pw;
        t_pgsel pn;
        logic   pg;

        n_state   = r_state;
        n_ret     = r_ret;
        n_er_addr = r_er_addr;
        n_er_end  = r_er_end;
        n_h0      = r_h0;
        n_h1      = r_h1;
        n_ready   = r_ready;
        n_ovld    = r_ovld;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_data    = r_data;
        n_act     = r_act;
        n_nw      = r_nw;
        n_recov   = r_recov;
        n_wptr    = r_wptr;
        n_var     = r_var;
        n_oval    = r_oval;
        n_ost     = r_ost;

        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = HDR_ERASED;
        w_sq    = '0;
        w_fin   = 1'b0;
        w_fst   = ST_OK;
        w_fval  = '0;
        w_fcmd  = r_cmd;

        pr = find_read(r_h0, r_h1);
        pw = find_write(r_h0, r_h1);
        pn = r_recov ? pw : find_erased(r_h0, r_h1);
        pg = 1'b0;

        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && !r_ovld) begin
                    n_cmd  = i_req.command;
                    n_key  = i_req.var_address;
                    n_data = i_req.write_value;
                    w_fcmd = i_req.command;
                    case (i_req.command)
                        CMD_READ: begin
                            if (!r_ready) begin
                                w_fin = 1'b1;
                                w_fst = ST_NOINIT;
                            end else if (pr == PG_NONE) begin
                                w_fin = 1'b1;
                                w_fst = ST_NOPAGE;
                            end else begin
                                w_sq.start = 1'b1;
                                w_sq.page  = pr[0];
                                w_sq.down  = 1'b1;
                                w_sq.mode  = SM_ADDR;
                                w_sq.key   = i_req.var_address;
                                n_state    = S_RSCAN;
                            end
                        end
                        CMD_WRITE: begin
                            if (!r_ready) begin
                                w_fin = 1'b1;
                                w_fst = ST_NOINIT;
                            end else if (pw == PG_NONE) begin
                                w_fin = 1'b1;
                                w_fst = ST_NOPAGE;
                            end else begin
                                w_sq.start = 1'b1;
                                w_sq.page  = pw[0];
                                w_sq.mode  = SM_ERASED;
                                n_nw       = pw[0];
                                n_state    = S_WSCAN;
                            end
                        end
                        CMD_INIT: begin
                            // header repair table; erase sweeps return to n_ret
                            n_state = S_ERASE;
                            if (r_h0 == HC_ERASED && r_h1 == HC_VALID) begin
                                pg    = 1'b0;
                                n_ret = S_FINOK;
                            end else if (r_h0 == HC_ERASED && r_h1 == HC_RECV) begin
                                pg    = 1'b0;
                                n_nw  = 1'b1;
                                n_ret = S_XEND;
                            end else if (r_h0 == HC_RECV && r_h1 == HC_ERASED) begin
                                pg    = 1'b1;
                                n_nw  = 1'b0;
                                n_ret = S_XEND;
                            end else if (r_h0 == HC_VALID && r_h1 == HC_ERASED) begin
                                pg    = 1'b1;
                                n_ret = S_FINOK;
                            end else if ((r_h0 == HC_RECV && r_h1 == HC_VALID) ||
                                         (r_h0 == HC_VALID && r_h1 != HC_VALID)) begin
                                // recover from slot 1 of the non-valid page
                                w_sq.start = 1'b1;
                                w_sq.page  = (r_h0 == HC_VALID);
                                w_sq.mode  = SM_ANY;
                                n_state    = S_RECRD;
                            end else begin
                                // format: erase page 0, mark it valid, erase page 1
                                pg    = 1'b0;
                                n_ret = S_FMT1;
                            end
                            if (n_state == S_ERASE) begin
                                n_er_addr = slot_addr(pg, SW'(0));
                                n_er_end  = slot_addr(pg, SW'(SLOTS_PER_PAGE - 1));
                                if (pg) n_h1 = HC_ERASED;
                                else    n_h0 = HC_ERASED;
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                            w_fst = ST_OK;
                        end
                    endcase
                end
            end
            S_ERASE: begin
                w_we      = 1'b1;
                w_waddr   = r_er_addr;
                w_wdata   = HDR_ERASED;
                n_er_addr = r_er_addr + AW'(1);
                if (r_er_addr == r_er_end) begin
                    n_state = r_ret;
                end
            end
            S_RSCAN: begin
                if (w_sr.done) begin
                    w_fin  = 1'b1;
                    w_fst  = w_sr.hit ? ST_OK : ST_NODATA;
                    w_fval = w_sr.hit ? w_sr.value : 16'd0;
                end
            end
            S_WSCAN: begin
                if (w_sr.done) begin
                    if (w_sr.hit) begin
                        w_we    = 1'b1;
                        w_waddr = slot_addr(r_nw, w_sr.slot);
                        w_wdata = {r_data, r_key, 32'd0};
                        w_fin   = 1'b1;
                        w_fst   = ST_OK;
                    end else begin
                        n_recov = 1'b0;
                        n_state = S_XSTART;
                    end
                end
            end
            S_XSTART: begin
                if (pr == PG_NONE || pn == PG_NONE) begin
                    w_fin = 1'b1;
                    w_fst = ST_NOPAGE;
                end else begin
                    n_act = pr[0];
                    n_nw  = pn[0];
                    if (!r_recov) begin
                        w_we    = 1'b1;
                        w_waddr = slot_addr(pn[0], SW'(0));
                        w_wdata = HDR_RECEIVE;
                        if (pn[0]) n_h1 = HC_RECV;
                        else       n_h0 = HC_RECV;
                    end
                    w_sq.start = 1'b1;
                    w_sq.page  = pn[0];
                    w_sq.mode  = SM_ERASED;
                    n_state    = S_XFIRST;
                end
            end
            S_XFIRST: begin
                if (w_sr.done) begin
                    if (!w_sr.hit) begin
                        w_fin = 1'b1;
                        w_fst = ST_WERR;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = slot_addr(r_nw, w_sr.slot);
                        w_wdata = {r_data, r_key, 32'd0};
                        n_wptr  = WPW'(w_sr.slot) + WPW'(1);
                        n_var   = '0;
                        n_state = S_XVAR;
                    end
                end
            end
            S_XVAR: begin
                if (r_var == VW'(NUM_VARS)) begin
                    n_er_addr = slot_addr(r_act, SW'(0));
                    n_er_end  = slot_addr(r_act, SW'(SLOTS_PER_PAGE - 1));
                    if (r_act) n_h1 = HC_ERASED;
                    else       n_h0 = HC_ERASED;
                    n_ret   = S_XEND;
                    n_state = S_ERASE;
                end else if (16'(r_var) == r_key) begin
                    n_var = r_var + VW'(1);
                end else begin
                    w_sq.start = 1'b1;
                    w_sq.page  = r_act;
                    w_sq.down  = 1'b1;
                    w_sq.mode  = SM_ADDR;
                    w_sq.key   = 16'(r_var);
                    n_state    = S_XVSCAN;
                end
            end
            S_XVSCAN: begin
                if (w_sr.done) begin
                    n_var   = r_var + VW'(1);
                    n_state = S_XVAR;
                    if (w_sr.hit) begin
                        if (r_wptr == WPW'(SLOTS_PER_PAGE)) begin
                            w_fin = 1'b1;
                            w_fst = ST_WERR;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = slot_addr(r_nw, r_wptr[SW-1:0]);
                            w_wdata = {w_sr.value, 16'(r_var), 32'd0};
                            n_wptr  = r_wptr + WPW'(1);
                        end
                    end
                end
            end
            S_XEND: begin
                w_we    = 1'b1;
                w_waddr = slot_addr(r_nw, SW'(0));
                w_wdata = HDR_VALID;
                if (r_nw) n_h1 = HC_VALID;
                else      n_h0 = HC_VALID;
                w_fin   = 1'b1;
                w_fst   = ST_OK;
            end
            S_RECRD: begin
                if (w_sr.done) begin
                    n_key   = w_sr.addr;
                    n_data  = w_sr.value;
                    n_recov = 1'b1;
                    n_state = S_XSTART;
                end
            end
            S_FMT1: begin
                w_we      = 1'b1;
                w_waddr   = slot_addr(1'b0, SW'(0));
                w_wdata   = HDR_VALID;
                n_h0      = HC_VALID;
                n_h1      = HC_ERASED;
                n_er_addr = slot_addr(1'b1, SW'(0));
                n_er_end  = slot_addr(1'b1, SW'(SLOTS_PER_PAGE - 1));
                n_ret     = S_FINOK;
                n_state   = S_ERASE;
            end
            S_FINOK: begin
                w_fin = 1'b1;
                w_fst = ST_OK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_state = S_IDLE;
            n_ovld  = 1'b1;
            n_oval  = w_fval;
            n_ost   = w_fst;
            // init reports any failure as a write error and sets ready on success
            if (w_fcmd == CMD_INIT) begin
                if (w_fst != ST_OK) n_ost = ST_WERR;
                else                n_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // clearing pass over the whole memory, then idle
            r_state   <= S_ERASE;
            r_ret     <= S_IDLE;
            r_er_addr <= '0;
            r_er_end  <= AW'(2 * SLOTS_PER_PAGE - 1);
            r_h0      <= HC_ERASED;
            r_h1      <= HC_ERASED;
            r_ready   <= 1'b0;
            r_ovld    <= 1'b0;
            r_cmd     <= CMD_READ;
            r_recov   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_er_addr <= n_er_addr;
            r_er_end  <= n_er_end;
            r_h0      <= n_h0;
            r_h1      <= n_h1;
            r_ready   <= n_ready;
            r_ovld    <= n_ovld;
            r_cmd     <= n_cmd;
            r_recov   <= n_recov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_data <= n_data;
        r_act  <= n_act;
        r_nw   <= n_nw;
        r_wptr <= n_wptr;
        r_var  <= n_var;
        r_oval <= n_oval;
        r_ost  <= n_ost;
    end
endmodule
